@@ sv/mgrad_pkg.sv @@
// ----------------------------------------------------------------------------
// mgrad_pkg
// Shared constants for the 3x3 morphological gradient core.
// ----------------------------------------------------------------------------
package mgrad_pkg;

    // Pixel and register field widths
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;

    // Configuration port shape
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Register reset values
    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;

    // Default line store depth
    localparam int MAX_WIDTH_DEF = 1024;

endpackage

@@ sv/morphological_gradient_3x3_core.sv @@
// ----------------------------------------------------------------------------
// morphological_gradient_3x3_core
// 3x3 morphological gradient over a raster-order grayscale pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels arrive on the s_axis channel (tdata = pixel, tuser = drain flag),
//   results leave on m_axis (tdata = gradient, tlast = last pixel of frame).
//   Frame size is set through the write port (index 0 width, 1 height) while
//   the core is idle. After the last pixel of a frame, send width+1 drain
//   transfers to flush the tail; each transfer from position width+1 of the
//   frame on yields exactly one result, earlier ones yield none.
//   Throughput: one transfer per cycle while m_axis is not stalled, set by the
//   single read and single write port of the line store, one access of each per item.
//   A transfer is registered into stage B together with its line store
//   read; the result register is loaded when stage B moves on, which a
//   stalled receiver can hold off.
//   Reset clears counters and flags and restores 640x480; line store and
//   window contents are not cleared and need no clearing pass.
//   A stalled receiver holds the result register; one further item may be
//   taken into the internal stage, then s_axis_tready drops until the
//   result is transferred. Items that give no result never wait.
// ----------------------------------------------------------------------------
module morphological_gradient_3x3_core #(
    parameter int MAX_WIDTH = mgrad_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_we,
    input  logic [mgrad_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mgrad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Pixel input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mgrad_pkg::PIX_W-1:0]        s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]                         s_axis_tuser,   // [0] drain
    // Gradient output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mgrad_pkg::PIX_W-1:0]        m_axis_tdata,   // [7:0] gradient
    output logic                               m_axis_tlast    // frame end
);

    localparam int PW = mgrad_pkg::PIX_W;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int SW = WW + 1;
    localparam int HW = mgrad_pkg::FH_W;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_item_ctrl;

    // Configuration registers
    logic [mgrad_pkg::FW_W-1:0] r_frame_width;
    logic [HW-1:0]              r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mgrad_pkg::FW_RESET;
            r_frame_height <= mgrad_pkg::FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mgrad_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[mgrad_pkg::FW_W-1:0];
                end
                mgrad_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[HW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective frame size
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        h_eff = (r_frame_height == '0) ? HW'(1) : r_frame_height;
    end

    // Handshake
    logic       r_b_valid;
    t_item_ctrl r_b_ctrl;
    logic       r_o_valid;
    logic       out_free;
    logic       b_go;
    logic       acc;

    assign out_free      = !r_o_valid || m_axis_tready;
    assign b_go          = r_b_valid && (!r_b_ctrl.emit || out_free);
    assign s_axis_tready = !r_b_valid || b_go;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Position counters, stepped on each input transfer
    logic [CW-1:0] r_in_col,  n_in_col;
    logic [HW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [HW-1:0] r_out_row, n_out_row;
    t_item_ctrl    acc_ctrl;

    always_comb begin
        logic          out_col_end;
        logic          out_row_end;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;

        acc_ctrl.emit = (r_in_row >= HW'(2)) || (r_in_row == HW'(1) && r_in_col != '0);

        // input position
        if ((SW'(r_in_col) + SW'(1)) >= SW'(w_eff)) begin
            n_in_col = '0;
            if (r_in_row != '1) begin
                n_in_row = r_in_row + HW'(1);
            end
        end else begin
            n_in_col = r_in_col + CW'(1);
        end

        // output position
        out_col_end = (SW'(r_out_col) + SW'(1)) >= SW'(w_eff);
        out_row_end = ((HW + 1)'(r_out_row) + (HW + 1)'(1)) >= (HW + 1)'(h_eff);
        acc_ctrl.interior = (r_out_row != '0) && !out_row_end &&
                            (r_out_col != '0) && !out_col_end;
        acc_ctrl.last     = out_row_end && out_col_end;

        if (acc_ctrl.emit) begin
            if (acc_ctrl.last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (out_col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + HW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Line store
    logic [2*PW-1:0] rd_data;
    logic [2*PW-1:0] wr_data;
    logic [PW-1:0]   b_top;
    logic [PW-1:0]   b_mid;
    logic [PW-1:0]   r_b_pix;
    logic [CW-1:0]   r_b_col;
    logic            r_b_fwd;
    logic [2*PW-1:0] r_fwd_data;

    mgrad_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (b_go),
        .i_waddr (r_b_col),
        .i_wdata (wr_data),
        .i_re    (acc),
        .i_raddr (r_in_col),
        .o_rdata (rd_data)
    );

    // Same column written on the edge of the read: take the written word
    always_comb begin
        if (r_b_fwd) begin
            b_top = r_fwd_data[2*PW-1:PW];
            b_mid = r_fwd_data[PW-1:0];
        end else begin
            b_top = rd_data[2*PW-1:PW];
            b_mid = rd_data[PW-1:0];
        end
    end

    // middle moves up, new pixel becomes middle
    assign wr_data = {b_mid, r_b_pix};

    // Stage B: item waiting on line store data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_ctrl  <= '0;
        end else if (acc) begin
            r_b_valid <= 1'b1;
            r_b_ctrl  <= acc_ctrl;
        end else if (b_go) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_pix    <= s_axis_tuser[0] ? '0 : s_axis_tdata;
            r_b_col    <= r_in_col;
            r_b_fwd    <= b_go && (r_b_col == r_in_col);
            r_fwd_data <= wr_data;
        end
    end

    // Window and range
    logic [PW-1:0] win_range;

    mgrad_window u_window (
        .i_clk   (i_clk),
        .i_load  (b_go),
        .i_top   (b_top),
        .i_mid   (b_mid),
        .i_pix   (r_b_pix),
        .o_range (win_range)
    );

    // Result register
    logic [PW-1:0] r_grad;
    logic          r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_go && r_b_ctrl.emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && r_b_ctrl.emit) begin
            r_grad <= r_b_ctrl.interior ? win_range : '0;
            r_last <= r_b_ctrl.last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_grad;
    assign m_axis_tlast  = r_last;

endmodule

@@ sv/mgrad_line_store.sv @@
// ----------------------------------------------------------------------------
// mgrad_line_store
// Dual line store: one memory word holds the upper and middle row pixels of a
// column. One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mgrad_line_store #(
    parameter int DEPTH = mgrad_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  logic [2*mgrad_pkg::PIX_W-1:0]   i_wdata,   // [7:0] middle, [15:8] upper
    input  logic                            i_re,
    input  logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic [2*mgrad_pkg::PIX_W-1:0]   o_rdata    // [7:0] middle, [15:8] upper
);

    logic [2*mgrad_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [2*mgrad_pkg::PIX_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, read-before-write on a shared address
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mgrad_window.sv @@
// ----------------------------------------------------------------------------
// mgrad_window
// 3x3 pixel window. Shifts in one new column per load and gives the range
// (maximum minus minimum) of the window as it stands after the shift.
// ----------------------------------------------------------------------------
module mgrad_window (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [mgrad_pkg::PIX_W-1:0]  i_top,
    input  logic [mgrad_pkg::PIX_W-1:0]  i_mid,
    input  logic [mgrad_pkg::PIX_W-1:0]  i_pix,
    output logic [mgrad_pkg::PIX_W-1:0]  o_range
);

    localparam int PW = mgrad_pkg::PIX_W;

    // r_win[row][col], col 2 is the newest column
    logic [PW-1:0] r_win [3][3];
    logic [PW-1:0] n_win [3][3];
    logic [PW-1:0] win_min;
    logic [PW-1:0] win_max;

    function automatic logic [PW-1:0] f_min(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PW-1:0] f_max(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Next window: shift left, new column on the right
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = i_top;
        n_win[1][2] = i_mid;
        n_win[2][2] = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win <= n_win;
        end
    end

    // Minimum and maximum over the nine taps, four compare levels deep
    always_comb begin
        win_min = f_min(f_min(f_min(n_win[0][0], n_win[0][1]),
                              f_min(n_win[0][2], n_win[1][0])),
                        f_min(f_min(n_win[1][1], n_win[1][2]),
                              f_min(n_win[2][0], f_min(n_win[2][1], n_win[2][2]))));
        win_max = f_max(f_max(f_max(n_win[0][0], n_win[0][1]),
                              f_max(n_win[0][2], n_win[1][0])),
                        f_max(f_max(n_win[1][1], n_win[1][2]),
                              f_max(n_win[2][0], f_max(n_win[2][1], n_win[2][2]))));
        o_range = win_max - win_min;
    end

endmodule

@@ sv/mgrad_checker.sv @@
// ----------------------------------------------------------------------------
// mgrad_checker
// Port-level checks for the 3x3 morphological gradient core.
// ----------------------------------------------------------------------------
module mgrad_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tready,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [mgrad_pkg::PIX_W-1:0]  m_axis_tdata,
    input  logic                         m_axis_tlast
);

    // Result held until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped before transfer");

    // Stalled result payload stays put
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // Out of reset: no result pending, input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("core not empty after reset");

    // Empty result register never back-pressures the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

bind morphological_gradient_3x3_core mgrad_checker u_mgrad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
